// File: hdl/prfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package prfd_pkg;

  // Command codes carried in the func field.
  localparam logic [2:0] FUNC_FILL    = 3'd0;
  localparam logic [2:0] FUNC_OUTLINE = 3'd1;
  localparam logic [2:0] FUNC_HLINE   = 3'd2;
  localparam logic [2:0] FUNC_VLINE   = 3'd3;
  localparam logic [2:0] FUNC_READ    = 3'd4;

  // One command beat.
  typedef struct packed {
    logic [2:0]         func;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [7:0]         extent_w;
    logic signed [7:0]  extent_h;
    logic               ink;
    logic [9:0]         byte_address;
  } prfd_in_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] read_data;
    logic       touched;
  } prfd_out_t;

endpackage

`default_nettype wire

// File: hdl/prfd_store.sv
`timescale 1ns / 1ps
`default_nettype none

// Single-port frame byte store with a registered read.
module prfd_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic [7:0]    wdata_i,
  output logic [7:0]         rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  // Write when enabled; the read returns the old contents in the next cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hdl/page_framebuffer_rect_draw_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Signals                              Beat
// in        input      in_valid_i, in_stall_o, in_data_i    one drawing or read command
// out       output     out_valid_o, out_stall_i, out_data_o one result per command
//
// After reset a clearing pass writes zero to every store byte, one byte per cycle
// (SCREEN_WIDTH * ceil(SCREEN_HEIGHT / 8) bytes, 1024 by default); commands stall meanwhile.
// A drawing command sets up each rectangle, starts each page band of it, then steps along the
// clipped width: each byte is a read and, if it changes, a write on the single store port.
// A read command returns the byte at byte_address, or zero if that lies outside the store.
// A new command is taken only when the sequencer is idle; a stalled result waits in the
// output register and a following command may be taken meanwhile.
module page_framebuffer_rect_draw_top
  import prfd_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 64
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire prfd_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output prfd_out_t      out_data_o
);

  localparam int unsigned PAGES = (SCREEN_HEIGHT + 7) / 8;
  localparam int unsigned STORE = SCREEN_WIDTH * PAGES;
  localparam int unsigned AW    = $clog2(STORE);
  localparam int unsigned CW    = $clog2(SCREEN_WIDTH + 1);
  localparam int unsigned RW    = $clog2(SCREEN_HEIGHT + 1);
  localparam int unsigned XW    = 18;

  localparam logic signed [XW-1:0] ZERO_S = '0;
  localparam logic signed [XW-1:0] ONE_S  = XW'(1);
  localparam logic signed [XW-1:0] W_S    = XW'(SCREEN_WIDTH);
  localparam logic signed [XW-1:0] H_S    = XW'(SCREEN_HEIGHT);
  localparam logic [AW-1:0]        LAST_A = AW'(STORE - 1);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_SETUP = 4'd2;
  localparam logic [3:0] S_ROWST = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_WR    = 4'd5;
  localparam logic [3:0] S_NXT   = 4'd6;
  localparam logic [3:0] S_READ  = 4'd7;
  localparam logic [3:0] S_RDOUT = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0]    state_q, state_d;
  prfd_in_t      cmd_q;
  logic [1:0]    sub_q;
  logic          touched_q;
  logic [7:0]    res_data_q;
  logic [CW-1:0] cx0_q, cx1_q, col_q;
  logic [RW-1:0] cy1_q, row_q, end_q;
  logic [AW-1:0] addr_q;
  logic [7:0]    mask_q;
  logic          out_valid_q;
  prfd_out_t     out_data_q;

  logic          accept;
  logic          out_free;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;
  logic [7:0]    new_byte;
  logic          changed;
  logic [31:0]   ba_wide;
  logic          ba_in_range;
  logic          last_sub;

  // Sub-rectangle and clipping signals.
  logic signed [XW-1:0] xs, ys, rx, ry, rw, rh, x1, y1;
  logic signed [XW-1:0] cx0_w, cx1_w, cy0_w, cy1_w;
  logic signed [XW-1:0] ws, hs;
  logic                 skip;
  logic                 rect_ok;

  // Page band signals.
  logic [RW:0]   band_base, band_end, band_lim;
  logic [3:0]    bot;
  logic [AW:0]   page_addr;
  logic [7:0]    band_mask;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign ba_wide  = 32'(cmd_q.byte_address);
  assign ba_in_range = ba_wide < STORE;
  assign last_sub = (cmd_q.func == FUNC_OUTLINE) ? (sub_q == 2'd3) : 1'b1;

  // Pick the current rectangle of the command and clip it to the screen.
  always_comb begin
    xs = XW'(cmd_q.pos_x);
    ys = XW'(cmd_q.pos_y);
    ws = $signed(XW'(cmd_q.extent_w));
    hs = XW'(cmd_q.extent_h);
    skip = 1'b0;
    rx = xs;
    ry = ys;
    rw = ws;
    rh = hs;
    case (cmd_q.func)
      FUNC_HLINE: begin
        rh = ONE_S;
      end
      FUNC_VLINE: begin
        rw = ONE_S;
      end
      FUNC_OUTLINE: begin
        skip = (cmd_q.extent_w == 8'd0) || (cmd_q.extent_h <= 8'sd0);
        case (sub_q)
          2'd0: begin
            rh = ONE_S;
          end
          2'd1: begin
            ry = ys + hs - ONE_S;
            rh = ONE_S;
          end
          2'd2: begin
            ry = ys + ONE_S;
            rw = ONE_S;
            rh = hs - XW'(2);
          end
          default: begin
            rx = xs + ws - ONE_S;
            ry = ys + ONE_S;
            rw = ONE_S;
            rh = hs - XW'(2);
          end
        endcase
      end
      default: begin
        skip = 1'b0;
      end
    endcase
    x1 = rx + rw;
    y1 = ry + rh;
    cx0_w = (rx < ZERO_S) ? ZERO_S : rx;
    cy0_w = (ry < ZERO_S) ? ZERO_S : ry;
    cx1_w = (x1 > W_S) ? W_S : x1;
    cy1_w = (y1 > H_S) ? H_S : y1;
    rect_ok = !skip && (rw > ZERO_S) && (rh > ZERO_S) && (cx1_w > cx0_w) && (cy1_w > cy0_w);
  end

  // Mask and start address of the page band that holds the current row.
  always_comb begin
    band_base = {1'b0, row_q[RW-1:3], 3'b000};
    band_lim  = band_base + (RW + 1)'(8);
    band_end  = (band_lim > {1'b0, cy1_q}) ? {1'b0, cy1_q} : band_lim;
    bot       = 4'(band_end - band_base);
    band_mask = (8'hFF << row_q[2:0]) & (8'hFF >> (4'd8 - bot));
    page_addr = (AW + 1)'(row_q[RW-1:3]) * (AW + 1)'(SCREEN_WIDTH);
  end

  // Read-modify-write of one byte.
  assign new_byte = cmd_q.ink ? (mem_rdata | mask_q) : (mem_rdata & ~mask_q);
  assign changed  = new_byte != mem_rdata;

  // Store port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = addr_q;
    mem_wdata = new_byte;
    case (state_q)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_wdata = 8'h00;
      end
      S_WR: begin
        mem_we = changed;
      end
      S_READ: begin
        mem_addr = ba_wide[AW-1:0];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  prfd_store #(
    .DEPTH (STORE),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.func == FUNC_READ) begin
            state_d = S_READ;
          end else if (in_data_i.func <= FUNC_VLINE) begin
            state_d = S_SETUP;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_CLR: begin
        if (addr_q == LAST_A) begin
          state_d = S_IDLE;
        end
      end
      S_SETUP: begin
        state_d = rect_ok ? S_ROWST : S_NXT;
      end
      S_ROWST: begin
        state_d = S_RD;
      end
      S_RD: begin
        state_d = S_WR;
      end
      S_WR: begin
        if (CW'(col_q + 1'b1) != cx1_q) begin
          state_d = S_RD;
        end else if (end_q != cy1_q) begin
          state_d = S_ROWST;
        end else begin
          state_d = S_NXT;
        end
      end
      S_NXT: begin
        state_d = last_sub ? S_FIN : S_SETUP;
      end
      S_READ: begin
        state_d = S_RDOUT;
      end
      S_RDOUT: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_CLR: begin
          addr_q <= AW'(addr_q + 1'b1);
        end
        S_ROWST: begin
          addr_q <= page_addr[AW-1:0] + AW'(cx0_q);
        end
        S_WR: begin
          addr_q <= AW'(addr_q + 1'b1);
        end
        default: begin
          addr_q <= addr_q;
        end
      endcase
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Command, geometry and result registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= in_data_i;
      sub_q      <= 2'd0;
      touched_q  <= 1'b0;
      res_data_q <= 8'h00;
    end
    case (state_q)
      S_SETUP: begin
        cx0_q <= CW'(cx0_w);
        cx1_q <= CW'(cx1_w);
        cy1_q <= RW'(cy1_w);
        row_q <= RW'(cy0_w);
      end
      S_ROWST: begin
        col_q  <= cx0_q;
        end_q  <= RW'(band_end);
        mask_q <= band_mask;
      end
      S_WR: begin
        touched_q <= touched_q | changed;
        col_q     <= CW'(col_q + 1'b1);
        if (CW'(col_q + 1'b1) == cx1_q) begin
          row_q <= end_q;
        end
      end
      S_NXT: begin
        sub_q <= 2'(sub_q + 1'b1);
      end
      S_RDOUT: begin
        res_data_q <= ba_in_range ? mem_rdata : 8'h00;
      end
      default: begin
      end
    endcase
    if (state_q == S_FIN && out_free) begin
      out_data_q.read_data <= res_data_q;
      out_data_q.touched   <= touched_q;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The store is only written during the clearing pass and the write step.
  a_we_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_CLR || state_q == S_WR))
    else $error("store written outside clearing or write step");

  // The column walk stays inside the clipped rectangle.
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD || state_q == S_WR) |-> (col_q >= cx0_q && col_q < cx1_q))
    else $error("column outside clipped rectangle");

  // A band always covers at least one row.
  a_mask_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD || state_q == S_WR) |-> mask_q != 8'h00)
    else $error("empty band mask");

  // Only drawing commands can report a change.
  a_touched_func: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && touched_q) |-> cmd_q.func <= FUNC_VLINE)
    else $error("touched set by a non-drawing command");

  // A read command goes straight to the store read.
  a_read_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.func == FUNC_READ) |=> state_q == S_READ)
    else $error("read command did not reach the read step");

endmodule

`default_nettype wire
